// File: sv/spwi_pkg.sv
package spwi_pkg;

	localparam int SPEED_W   = 10;
	localparam int HOLD_W    = 16;
	localparam int TIME_W    = 32;
	localparam int PROG_W    = 17;
	localparam int FRAC_W    = 16;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;
	localparam int CORNER_W  = 24;
	localparam int MAG_W     = 23;
	localparam int VAL_W     = 26;
	localparam int DT_W      = 17;
	localparam int PROD_W    = DT_W + SPEED_W;
	localparam int DIVR_W    = 17;
	localparam int CNT_W     = 4;
	localparam int MUL_STEPS = SPEED_W;
	localparam int DIV_STEPS = FRAC_W;
	localparam int LERP_STEPS = FRAC_W;

	localparam logic [TIME_W-1:0] MIN_TICK_MS = 32'd5;
	localparam logic [PROG_W-1:0] ONE_Q16     = 17'h10000;

	// event kinds
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_STOP  = 2'd2;

	// output commands
	localparam logic [1:0] CMD_MOVE    = 2'd0;
	localparam logic [1:0] CMD_LEAD_IN = 2'd1;
	localparam logic [1:0] CMD_HOME    = 2'd2;

	// register index, decoded from paddr[2]
	localparam logic REG_SPEED = 1'b0;
	localparam logic REG_HOLD  = 1'b1;

	localparam logic [HOLD_W-1:0]  RST_HOLD  = 16'd200;
	localparam logic [SPEED_W-1:0] RST_SPEED = 10'd75;

	// 100 * edge length in 0.1 mm: side 62.6 mm, diagonal 88.5 mm
	localparam logic [DIVR_W-1:0] DIV_SIDE = 17'd62600;
	localparam logic [DIVR_W-1:0] DIV_DIAG = 17'd88500;

	// rotated square corners in Q16 mm, rows x, y, z
	localparam logic signed [CORNER_W-1:0] CORNER [3][4] = '{
		'{24'sd6068128, 24'sd4016851, 24'sd4016851, 24'sd6068128},
		'{-24'sd1286174, -24'sd4839090, -24'sd4839090, -24'sd1286174},
		'{24'sd5852365, 24'sd5852365, 24'sd1749811, 24'sd1749811}
	};

	function automatic logic [DIVR_W-1:0] edge_div(input logic [1:0] a, input logic [1:0] b);
		logic [1:0] d;
		d = a ^ b;
		if (d == 2'b00) begin
			return '0;
		end else if (d == 2'b10) begin
			return DIV_DIAG;
		end else begin
			return DIV_SIDE;
		end
	endfunction

endpackage

// File: sv/square_path_waypoint_interpolator_top.sv
// a start or stop item goes straight to the emit state, which loads the result once the
//   output is free; ticks that end in dwell, wait or filtering give nothing and the block
//   is ready next cycle; a moving tick passes through the multiply, check, divide,
//   interpolate and emit states, going from check or divide straight to emit at a corner
// one item at a time: the next item is taken the cycle after the result is loaded;
//   reset (arst_n low, async): walk stopped, 75 mm/s, 200 ms
module square_path_waypoint_interpolator_top #(
	parameter int NUM_CORNERS   = 4,
	parameter int POS_FRAC_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// item channel
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [1:0]                      kind,
	input  logic [spwi_pkg::TIME_W-1:0]     now_ms,
	input  logic                            planner_idle,
	// result channel
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [1:0]                      command,
	output logic signed [15:0]              pos_x,
	output logic signed [15:0]              pos_y,
	output logic signed [15:0]              pos_z,
	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [spwi_pkg::ADDR_W-1:0]     paddr,
	input  logic [spwi_pkg::DATA_W-1:0]     pwdata,
	output logic [spwi_pkg::DATA_W-1:0]     prdata,
	output logic                            pready
);
	import spwi_pkg::*;

	localparam int IDX_W = $clog2(NUM_CORNERS);
	// right shift from Q16 to the output format
	localparam int SH = 16 - POS_FRAC_BITS;
	localparam logic signed [VAL_W:0] RND = (27'sd1 <<< SH) >>> 1;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_CHK  = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_LERP = 6'b010000,
		ST_EMIT = 6'b100000
	} state_t;

	// Q16 value to output format: round half up, saturate to 16 bits
	function automatic logic [15:0] to_out(input logic signed [VAL_W-1:0] v);
		logic signed [VAL_W:0] r;
		logic signed [VAL_W:0] s;
		r = (VAL_W+1)'(v) + RND;
		s = r >>> SH;
		if (s > 27'sd32767) begin
			return 16'h7FFF;
		end else if (s < -27'sd32768) begin
			return 16'h8000;
		end else begin
			return s[15:0];
		end
	endfunction

	// sequencer
	state_t                   state_q;
	logic [CNT_W-1:0]         cnt_q;

	// configuration registers
	logic [SPEED_W-1:0]       speed_q;
	logic [HOLD_W-1:0]        hold_q;

	// walk state
	logic                     running_q;
	logic                     lead_in_q;
	logic                     holding_q;
	logic [IDX_W-1:0]         edge_q;
	logic [PROG_W-1:0]        progress_q;
	logic [TIME_W-1:0]        last_tick_q;
	logic [TIME_W-1:0]        hold_start_q;

	// serial multiply speed * dt
	logic                     sat_q;
	logic [PROD_W-1:0]        mcand_q;
	logic [SPEED_W-1:0]       mplier_q;
	logic [PROD_W-1:0]        prod_q;

	// serial restoring divide by 100 * edge length
	logic [DIVR_W-1:0]        rem_q;
	logic [FRAC_W-1:0]        quot_q;

	// serial interpolation, one progress bit per cycle, three axes side by side
	logic [FRAC_W-1:0]        t_q;
	logic [MAG_W-1:0]         mag_q [3];
	logic                     neg_q [3];
	logic [MAG_W-1:0]         acc_q [3];

	// staged result, before rounding
	logic [1:0]               cmd_q;
	logic signed [VAL_W-1:0]  v_q [3];

	// result register
	logic                     result_valid_q;
	logic [1:0]               command_q;
	logic signed [15:0]       pos_q [3];

	logic                     accept;
	logic                     out_free;
	logic                     cfg_wr;
	logic [TIME_W-1:0]        dt;
	logic [TIME_W-1:0]        dt_hold;
	logic [IDX_W-1:0]         next_idx;
	logic [1:0]               a_idx;
	logic [1:0]               b_idx;
	logic [DIVR_W-1:0]        div_d;
	logic                     full_step;
	logic [DIVR_W:0]          rem_dbl;
	logic                     rem_ge;
	logic [FRAC_W-1:0]        quot_nx;
	logic [PROG_W-1:0]        prog_sum;
	logic                     mul_last;
	logic                     div_last;
	logic                     lerp_last;
	logic                     reach;
	logic                     lerp_go;
	logic signed [CORNER_W-1:0] ca [3];
	logic signed [CORNER_W-1:0] cb [3];
	logic signed [CORNER_W:0]   delta [3];
	logic [MAG_W:0]           lsum [3];
	logic [MAG_W-1:0]         acc_nx [3];
	logic signed [VAL_W-1:0]  lerp_v [3];

	assign accept   = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);
	assign out_free = !result_valid_q || !result_stall;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;

	assign dt       = now_ms - last_tick_q;
	assign dt_hold  = now_ms - hold_start_q;
	assign next_idx = (edge_q == IDX_W'(NUM_CORNERS - 1)) ? '0 : edge_q + 1'b1;
	assign a_idx    = edge_q[1:0];
	assign b_idx    = next_idx[1:0];
	assign div_d    = edge_div(a_idx, b_idx);

	// a step of a full edge or more saturates at 1.0; zero-length edge too
	assign full_step = sat_q || (div_d == '0) || (prod_q >= PROD_W'(div_d));

	assign rem_dbl  = {rem_q, 1'b0};
	assign rem_ge   = (rem_dbl >= {1'b0, div_d});
	assign quot_nx  = {quot_q[FRAC_W-2:0], rem_ge};
	assign prog_sum = progress_q + {1'b0, quot_nx};

	assign mul_last  = (cnt_q == CNT_W'(MUL_STEPS - 1));
	assign div_last  = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign lerp_last = (cnt_q == CNT_W'(LERP_STEPS - 1));

	assign reach   = ((state_q == ST_CHK) && full_step) ||
		((state_q == ST_DIV) && div_last && prog_sum[FRAC_W]);
	assign lerp_go = (state_q == ST_DIV) && div_last && !prog_sum[FRAC_W];

	always_comb begin
		for (int ax = 0; ax < 3; ax++) begin
			ca[ax]     = CORNER[ax][a_idx];
			cb[ax]     = CORNER[ax][b_idx];
			delta[ax]  = (CORNER_W+1)'(cb[ax]) - (CORNER_W+1)'(ca[ax]);
			lsum[ax]   = {1'b0, acc_q[ax]} + (t_q[0] ? {1'b0, mag_q[ax]} : '0);
			acc_nx[ax] = lsum[ax][MAG_W:1];
			lerp_v[ax] = VAL_W'(ca[ax]) + (neg_q[ax] ?
				-$signed(VAL_W'(acc_nx[ax])) : $signed(VAL_W'(acc_nx[ax])));
		end
	end

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= RST_SPEED;
			hold_q  <= RST_HOLD;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_SPEED) begin
				speed_q <= pwdata[SPEED_W-1:0];
			end else begin
				hold_q <= pwdata[HOLD_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_SPEED) begin
			prdata = DATA_W'(speed_q);
		end else begin
			prdata = DATA_W'(hold_q);
		end
	end

	// sequencer and walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			running_q    <= 1'b0;
			lead_in_q    <= 1'b0;
			holding_q    <= 1'b0;
			edge_q       <= '0;
			progress_q   <= '0;
			last_tick_q  <= '0;
			hold_start_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (kind)
							KIND_START: begin
								running_q   <= 1'b1;
								lead_in_q   <= 1'b1;
								holding_q   <= 1'b0;
								edge_q      <= '0;
								progress_q  <= '0;
								last_tick_q <= now_ms;
								state_q     <= ST_EMIT;
							end
							KIND_STOP: begin
								running_q <= 1'b0;
								state_q   <= ST_EMIT;
							end
							KIND_TICK: begin
								if (running_q) begin
									if (lead_in_q) begin
										// wait for the lead-in move to finish
										if (planner_idle) begin
											lead_in_q   <= 1'b0;
											last_tick_q <= now_ms;
										end
									end else if (dt >= MIN_TICK_MS) begin
										last_tick_q <= now_ms;
										if (holding_q) begin
											// dwell at the corner, then take the next edge
											if (dt_hold >= TIME_W'(hold_q)) begin
												holding_q  <= 1'b0;
												edge_q     <= next_idx;
												progress_q <= '0;
											end
										end else begin
											cnt_q   <= '0;
											state_q <= ST_MUL;
										end
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (mul_last) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					cnt_q <= '0;
					if (full_step) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_last) begin
						cnt_q   <= '0;
						state_q <= prog_sum[FRAC_W] ? ST_EMIT : ST_LERP;
						if (!prog_sum[FRAC_W]) begin
							progress_q <= prog_sum;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_LERP: begin
					cnt_q <= cnt_q + 1'b1;
					if (lerp_last) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// corner reached: clamp progress and start the dwell
			if (reach) begin
				progress_q   <= ONE_Q16;
				holding_q    <= 1'b1;
				hold_start_q <= last_tick_q;
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			sat_q    <= (speed_q != '0) && (dt[TIME_W-1:DT_W] != '0);
			mcand_q  <= PROD_W'(dt[DT_W-1:0]);
			mplier_q <= speed_q;
			prod_q   <= '0;
			if (kind == KIND_START) begin
				cmd_q <= CMD_LEAD_IN;
				for (int ax = 0; ax < 3; ax++) begin
					v_q[ax] <= VAL_W'(CORNER[ax][0]);
				end
			end else begin
				cmd_q <= CMD_HOME;
				for (int ax = 0; ax < 3; ax++) begin
					v_q[ax] <= '0;
				end
			end
		end
		if (state_q == ST_MUL) begin
			prod_q   <= prod_q + (mplier_q[0] ? mcand_q : '0);
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
		if (state_q == ST_CHK) begin
			rem_q  <= prod_q[DIVR_W-1:0];
			quot_q <= '0;
		end
		if (state_q == ST_DIV) begin
			rem_q  <= rem_ge ? DIVR_W'(rem_dbl - {1'b0, div_d}) : rem_dbl[DIVR_W-1:0];
			quot_q <= quot_nx;
		end
		if (lerp_go) begin
			t_q <= prog_sum[FRAC_W-1:0];
			for (int ax = 0; ax < 3; ax++) begin
				neg_q[ax] <= delta[ax][CORNER_W];
				mag_q[ax] <= delta[ax][CORNER_W] ? MAG_W'(-delta[ax]) : MAG_W'(delta[ax]);
				acc_q[ax] <= '0;
			end
		end
		if (state_q == ST_LERP) begin
			t_q <= t_q >> 1;
			for (int ax = 0; ax < 3; ax++) begin
				acc_q[ax] <= acc_nx[ax];
			end
			if (lerp_last) begin
				cmd_q <= CMD_MOVE;
				for (int ax = 0; ax < 3; ax++) begin
					v_q[ax] <= lerp_v[ax];
				end
			end
		end
		if (reach) begin
			cmd_q <= CMD_MOVE;
			for (int ax = 0; ax < 3; ax++) begin
				v_q[ax] <= VAL_W'(cb[ax]);
			end
		end
		if ((state_q == ST_EMIT) && out_free) begin
			command_q <= cmd_q;
			for (int ax = 0; ax < 3; ax++) begin
				pos_q[ax] <= to_out(v_q[ax]);
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign command      = command_q;
	assign pos_x        = pos_q[0];
	assign pos_y        = pos_q[1];
	assign pos_z        = pos_q[2];

endmodule

// File: sv/spwi_checker.sv
module spwi_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	input  logic                            item_stall,
	input  logic [1:0]                      kind,
	input  logic                            result_valid,
	input  logic                            result_stall,
	input  logic [1:0]                      command,
	input  logic signed [15:0]              pos_x,
	input  logic signed [15:0]              pos_y,
	input  logic signed [15:0]              pos_z,
	input  logic                            psel,
	input  logic                            pwrite,
	input  logic [spwi_pkg::ADDR_W-1:0]     paddr,
	input  logic [spwi_pkg::DATA_W-1:0]     prdata
);
	import spwi_pkg::*;

	// a held result stays offered
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// return home always carries a zero position
	a_home_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (command == CMD_HOME) |-> (pos_x == 16'sd0) && (pos_y == 16'sd0) &&
			(pos_z == 16'sd0))
		else $error("home command with nonzero position");

	// a start or stop item occupies the block while its result is staged
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && ((kind == KIND_START) || (kind == KIND_STOP)) |=>
			item_stall)
		else $error("item taken while start or stop result pending");

	// speed register reads back no more than its width
	a_speed_read: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite && (paddr[2] == REG_SPEED) |-> (prdata[DATA_W-1:SPEED_W] == '0))
		else $error("speed read has stray upper bits");

endmodule

bind square_path_waypoint_interpolator_top spwi_checker u_spwi_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.kind         (kind),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.command      (command),
	.pos_x        (pos_x),
	.pos_y        (pos_y),
	.pos_z        (pos_z),
	.psel         (psel),
	.pwrite       (pwrite),
	.paddr        (paddr),
	.prdata       (prdata)
);
